### hw/rtl/rwpf_pkg.sv
`default_nettype none

package rwpf_pkg;

  localparam logic [31:0] CrcPoly = 32'h04C1_1DB7;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_SEED   = 3'd0,
    CFG_START  = 3'd1,
    CFG_HEADER = 3'd2,
    CFG_END    = 3'd3,
    CFG_VER    = 3'd4
  } cfg_idx_e;

  // word slot within one item's share of the packet
  typedef enum logic [7:0] {
    PH_START = 8'b0000_0001,
    PH_LEN   = 8'b0000_0010,
    PH_VER   = 8'b0000_0100,
    PH_HDR   = 8'b0000_1000,
    PH_EVEN  = 8'b0001_0000,
    PH_ODD   = 8'b0010_0000,
    PH_END   = 8'b0100_0000,
    PH_CRC   = 8'b1000_0000
  } phase_e;

  // one 32-bit word into the augmented crc, msb first (xor network)
  function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [31:0] w);
    logic [31:0] c;
    logic        top;
    c = crc;
    for (int i = 31; i >= 0; i--) begin
      top = c[31];
      c   = {c[30:0], w[i]};
      if (top) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  // per-byte xor parity, bit i for byte i
  function automatic logic [3:0] byte_par(input logic [31:0] w);
    logic [3:0] p;
    for (int b = 0; b < 4; b++) begin
      p[b] = ^w[8*b +: 8];
    end
    return p;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/register_write_packet_framer.sv
`default_nettype none

// an item's words go through the item register and then the single 32-bit
// output word register; each pair sends its even and odd words, the first
//   pair of a packet also start, length, version and header, the last end and crc
// reset: asynchronous, active low; clears config registers, pair count, crc
//   and all valid flags
module register_write_packet_framer #(
  parameter int MAX_PAIRS = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  // input items
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  pair_count_i,
  input  wire logic [31:0] even_word_i,
  input  wire logic [31:0] odd_word_i,
  // packet words
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      packet_word_o,
  output logic             last_word_o
);
  import rwpf_pkg::*;

  // config registers
  logic [31:0] seed_q, start_q, header_q, end_q, ver_q;

  // pairs still expected in the open packet, zero when none is open
  logic [7:0]  pairs_left_q, pairs_left_d;
  logic [31:0] crc_q, crc_d;

  // item register: the item whose words are being sent
  logic        cur_valid_q;
  phase_e      phase_q, phase_d;
  logic        cur_last_q;
  logic [9:0]  cur_len_q;
  logic [31:0] cur_even_q, cur_odd_q;

  // output word register
  logic        out_valid_q;
  logic [31:0] out_word_q;
  logic        out_last_q;

  logic        adv, done_now, in_acc;
  logic [7:0]  pc_sat, pl_eff;
  logic        open_pkt;
  logic [31:0] odd_x, word_sel;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= '0;
      start_q  <= '0;
      header_q <= '0;
      end_q    <= '0;
      ver_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SEED:   seed_q   <= cfg_data_i;
        CFG_START:  start_q  <= cfg_data_i;
        CFG_HEADER: header_q <= cfg_data_i;
        CFG_END:    end_q    <= cfg_data_i;
        CFG_VER:    ver_q    <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // a word moves to the output register whenever that register is free
  assign adv      = cur_valid_q && (!out_valid_q || !out_stall_i);
  // item finishes with its odd word, or with the crc when it closes the packet
  assign done_now = adv && ((phase_q == PH_ODD && !cur_last_q) || phase_q == PH_CRC);
  // next item may enter in the cycle the current one sends its final word
  assign in_stall_o = cur_valid_q && !done_now;
  assign in_acc     = in_valid_i && !in_stall_o;

  // pair count: zero means one pair, saturate at MAX_PAIRS
  always_comb begin
    pc_sat = (pair_count_i == 8'd0) ? 8'd1 : pair_count_i;
    if (int'(pc_sat) > MAX_PAIRS) begin
      pc_sat = 8'(MAX_PAIRS);
    end
  end

  assign open_pkt     = (pairs_left_q == 8'd0);
  assign pl_eff       = open_pkt ? pc_sat : pairs_left_q;
  assign pairs_left_d = in_acc ? (pl_eff - 8'd1) : pairs_left_q;

  assign odd_x = cur_odd_q | {byte_par(cur_odd_q), byte_par(cur_even_q), 24'd0};

  // word for the current slot and the crc it leaves behind
  always_comb begin
    word_sel = '0;
    crc_d    = crc_q;
    phase_d  = phase_q;
    unique case (phase_q)
      PH_START: begin
        word_sel = start_q;
        phase_d  = PH_LEN;
      end
      PH_LEN: begin
        word_sel = {22'd0, cur_len_q};
        phase_d  = PH_VER;
      end
      PH_VER: begin
        word_sel = ver_q;
        crc_d    = crc_feed(seed_q, ver_q);
        phase_d  = PH_HDR;
      end
      PH_HDR: begin
        word_sel = header_q;
        crc_d    = crc_feed(crc_q, header_q);
        phase_d  = PH_EVEN;
      end
      PH_EVEN: begin
        word_sel = cur_even_q;
        crc_d    = crc_feed(crc_q, cur_even_q);
        phase_d  = PH_ODD;
      end
      PH_ODD: begin
        word_sel = odd_x;
        crc_d    = crc_feed(crc_q, odd_x);
        phase_d  = PH_END;
      end
      PH_END: begin
        word_sel = end_q;
        phase_d  = PH_CRC;
      end
      PH_CRC: begin
        // finalize: push 32 zero bits through
        word_sel = crc_feed(crc_q, 32'd0);
        phase_d  = PH_START;
      end
      default: begin
        word_sel = '0;
        phase_d  = PH_START;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q  <= 1'b0;
      phase_q      <= PH_START;
      pairs_left_q <= '0;
      crc_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      pairs_left_q <= pairs_left_d;
      if (adv) begin
        crc_q <= crc_d;
      end
      if (in_acc) begin
        cur_valid_q <= 1'b1;
        phase_q     <= open_pkt ? PH_START : PH_EVEN;
      end else if (done_now) begin
        cur_valid_q <= 1'b0;
      end else if (adv) begin
        phase_q <= phase_d;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_even_q <= even_word_i;
      cur_odd_q  <= odd_word_i;
      cur_last_q <= (pl_eff == 8'd1);
      cur_len_q  <= {1'b0, pc_sat, 1'b0} + 10'd5;
    end
    if (adv) begin
      out_word_q <= word_sel;
      out_last_q <= (phase_q == PH_CRC);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign packet_word_o = out_word_q;
  assign last_word_o   = out_last_q;

`ifndef SYNTHESIS
  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("slot code not one-hot");

  a_idle_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cur_valid_q |-> !in_stall_o)
    else $error("input stalled with no item in flight");

  a_open_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pairs_left_q == 8'd0) |=> (cur_valid_q && phase_q == PH_START))
    else $error("new packet did not begin with the start word");

  a_crc_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (phase_q == PH_END || phase_q == PH_CRC)) |-> cur_last_q)
    else $error("packet trailer sent for a pair that does not close it");

  a_close_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pl_eff == 8'd1) |=> (pairs_left_q == 8'd0))
    else $error("closing pair left the packet open");
`endif

endmodule

`default_nettype wire

### bench/packet_scoreboard_pkg.sv
package packet_scoreboard_pkg;

  import rwpf_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } packet_word_t;

  class packet_scoreboard;
    int unsigned  max_pairs;
    logic [31:0]  seed_reg;
    logic [31:0]  start_reg;
    logic [31:0]  header_reg;
    logic [31:0]  end_reg;
    logic [31:0]  version_reg;
    logic [7:0]   pairs_open;
    logic [31:0]  crc_run;
    packet_word_t expected_words[$];
    int           errors;

    function new(int unsigned max_pairs);
      this.max_pairs = max_pairs;
      seed_reg       = '0;
      start_reg      = '0;
      header_reg     = '0;
      end_reg        = '0;
      version_reg    = '0;
      pairs_open     = '0;
      crc_run        = '0;
      errors         = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CFG_SEED:   seed_reg = data;
        CFG_START:  start_reg = data;
        CFG_HEADER: header_reg = data;
        CFG_END:    end_reg = data;
        CFG_VER:    version_reg = data;
        default: ;
      endcase
    endfunction

    // augmented crc-32, msb first
    static function logic [31:0] crc_step(logic [31:0] crc, logic [31:0] w);
      logic [31:0] c;
      c = crc;
      for (int i = 31; i >= 0; i--) begin
        if (c[31]) begin
          c = {c[30:0], w[i]} ^ CrcPoly;
        end else begin
          c = {c[30:0], w[i]};
        end
      end
      return c;
    endfunction

    static function logic [3:0] byte_parity(logic [31:0] w);
      return {^w[31:24], ^w[23:16], ^w[15:8], ^w[7:0]};
    endfunction

    function void push(logic [31:0] word, logic last);
      packet_word_t pw;
      pw.word = word;
      pw.last = last;
      expected_words.push_back(pw);
    endfunction

    // expected words for one accepted pair
    function void note_pair(logic [7:0] count, logic [31:0] even, logic [31:0] odd);
      int unsigned n;
      logic [31:0] odd_tagged;
      if (pairs_open == 0) begin
        n = count;
        if (n == 0) n = 1;
        if (n > max_pairs) n = max_pairs;
        pairs_open = 8'(n);
        push(start_reg, 1'b0);
        push(32'(2 * n + 5), 1'b0);
        push(version_reg, 1'b0);
        push(header_reg, 1'b0);
        crc_run = crc_step(crc_step(seed_reg, version_reg), header_reg);
      end
      odd_tagged = odd | {byte_parity(odd), byte_parity(even), 24'h0};
      push(even, 1'b0);
      push(odd_tagged, 1'b0);
      crc_run = crc_step(crc_step(crc_run, even), odd_tagged);
      pairs_open--;
      if (pairs_open == 0) begin
        push(end_reg, 1'b0);
        push(crc_step(crc_run, 32'h0), 1'b1);
      end
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_word(logic [31:0] word, logic last);
      packet_word_t exp;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word %h last %b", word, last));
      end else begin
        exp = expected_words.pop_front();
        if (word !== exp.word) begin
          report($sformatf("packet_word %h, expected %h", word, exp.word));
        end
        if (last !== exp.last) begin
          report($sformatf("last_word %b, expected %b (word %h)", last, exp.last, word));
        end
      end
    endtask

    function int pending();
      return expected_words.size();
    endfunction

    task flush_check();
      if (pending() != 0) begin
        report($sformatf("%0d expected words never came", pending()));
      end
    endtask
  endclass

endpackage

### bench/tb_register_write_packet_framer.sv
module tb_register_write_packet_framer;

  timeunit 1ns;
  timeprecision 1ps;

  import rwpf_pkg::*;
  import packet_scoreboard_pkg::*;

  localparam int MaxPairs   = 128;
  localparam int LongHold   = 300;     // receiver hold-off, in cycles
  localparam int CycleLimit = 200000;  // generous bound on the whole run
  localparam int DrainLimit = 5000;    // end-of-run wait for stragglers

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  pair_count_i;
  logic [31:0] even_word_i;
  logic [31:0] odd_word_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] packet_word_o;
  logic        last_word_o;

  // idling knobs, percent chance of a burst per item or per cycle
  int          gap_pct;
  int          stall_pct;
  logic        long_hold_req;
  int          cycle_count;

  packet_scoreboard sb;

  register_write_packet_framer #(
    .MAX_PAIRS(MaxPairs)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pair_count_i (pair_count_i),
    .even_word_i  (even_word_i),
    .odd_word_i   (odd_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .packet_word_o(packet_word_o),
    .last_word_o  (last_word_o)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run-time guard
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_register_write_packet_framer failed");
      $finish;
    end
  end

  // output side: every accepted word goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_word(packet_word_o, last_word_o);
    end
  end

  // receiver: random stall bursts, or one long hold-off
  // when asked; the hold is counted here so the sender keeps going meanwhile
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHold - 1) @(negedge clk_i);
        long_hold_req = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(0, 10)) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // one register write; valid drops on the following falling edge
  task automatic write_cfg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_regs(logic [31:0] seed, logic [31:0] start_w,
                              logic [31:0] header_w, logic [31:0] end_w,
                              logic [31:0] version_w);
    write_cfg(CFG_SEED, seed);
    write_cfg(CFG_START, start_w);
    write_cfg(CFG_HEADER, header_w);
    write_cfg(CFG_END, end_w);
    write_cfg(CFG_VER, version_w);
  endtask

  // offer one pair, maybe after an idle burst; valid stays high afterwards
  task automatic send_pair(logic [7:0] count, logic [31:0] even, logic [31:0] odd);
    int burst;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      burst = $urandom_range(1, 11);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (burst - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    pair_count_i <= count;
    even_word_i  <= even;
    odd_word_i   <= odd;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pair(count, even, odd);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // sender pause until every expected word is out
  task automatic drain();
    stop_sending();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // pair count for a packet start: mostly short packets, some zero counts
  function automatic logic [7:0] start_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 18) return 8'($urandom_range(7, 40));
    return 8'($urandom_range(1, 6));
  endfunction

  // random pairs; inside a packet the count field is pure noise
  task automatic random_pairs(int n);
    logic [7:0] count;
    repeat (n) begin
      if (sb.pairs_open == 0) begin
        count = start_count();
      end else begin
        count = 8'($urandom_range(0, 255));
      end
      send_pair(count, rand_word(), rand_word());
    end
  endtask

  // finish whatever packet is still open
  task automatic close_packet();
    while (sb.pairs_open != 0) begin
      send_pair(8'($urandom_range(0, 255)), rand_word(), rand_word());
    end
  endtask

  initial begin
    int waited;
    sb            = new(MaxPairs);
    gap_pct       = 0;
    stall_pct     = 0;
    long_hold_req = 1'b0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_SEED;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    pair_count_i  = '0;
    even_word_i   = '0;
    odd_word_i    = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // registers still at reset: a single pair, then a zero count
    send_pair(8'd1, 32'h0000_0000, 32'h0000_0000);
    send_pair(8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // all ones everywhere; writes to spare indexes must change nothing
    program_regs('1, '1, '1, '1, '1);
    for (int i = int'(CFG_VER) + 1; i < 8; i++) begin
      write_cfg(3'(i), $urandom);
    end

    // directed pairs: mid-packet counts are ignored, parity bit patterns
    gap_pct   = 20;
    stall_pct = 20;
    send_pair(8'd3, 32'h0000_0001, 32'h8000_0000);
    send_pair(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(8'd0, 32'h0100_8001, 32'h0080_0101);
    send_pair(8'd1, 32'h0000_00FF, 32'h0000_0001);
    send_pair(8'd2, 32'h1234_5678, 32'h0F0F_F0F0);
    send_pair(8'd200, 32'h8080_8080, 32'h7F7F_7F7F);
    drain();

    // the receiver holds off for a long stretch while the sender keeps
    // offering back to back
    program_regs(32'h0000_0000, 32'hC0DE_0001, 32'h4EAD_0002,
                 32'hE0D0_0003, 32'h0001_0203);
    gap_pct       = 0;
    stall_pct     = 0;
    long_hold_req = 1'b1;
    random_pairs(25);
    // sender waits until every word is out
    drain();
    gap_pct   = 25;
    stall_pct = 25;
    random_pairs(15);
    drain();

    // random packets under several register settings
    program_regs($urandom, $urandom, $urandom, $urandom, $urandom);
    gap_pct   = 30;
    stall_pct = 30;
    random_pairs(20);
    drain();

    program_regs('1, '0, $urandom, '0, $urandom);
    gap_pct   = 10;
    stall_pct = 50;
    random_pairs(20);
    drain();

    // no idling on either side from here on
    program_regs($urandom, $urandom, $urandom, $urandom, $urandom);
    gap_pct   = 0;
    stall_pct = 0;
    random_pairs(10);
    close_packet();
    drain();
    // oversized count saturates to the maximum packet, still open at the end
    program_regs($urandom, $urandom, $urandom, $urandom, $urandom);
    send_pair(8'd255, rand_word(), rand_word());
    random_pairs(10);
    stop_sending();

    // let the tail of the last item come out, with a bound
    waited = 0;
    while (sb.pending() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    sb.flush_check();
    if (sb.errors == 0) begin
      $display("tb_register_write_packet_framer passed");
    end else begin
      $display("tb_register_write_packet_framer failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/rwpf_pkg.sv
hw/rtl/register_write_packet_framer.sv
bench/packet_scoreboard_pkg.sv
bench/tb_register_write_packet_framer.sv
